// ----- rtl/core/fhps_pkg.sv -----
package fhps_pkg;

	localparam int PIXELS_DEF = 64;

	localparam logic [6:0] NUM_PIXELS_RST   = 7'd50;
	localparam logic [7:0] SPARK_CHANCE_RST = 8'd120;

	// config register indexes
	localparam logic CFG_NUM_PIXELS   = 1'b0;
	localparam logic CFG_SPARK_CHANCE = 1'b1;

	// floor(x/3) = (x*683) >> 11 for x < 2048
	localparam logic [19:0] DIV3_MUL   = 20'd683;
	localparam int          DIV3_SHIFT = 11;

	// t192 = (h*191 + 127) / 255
	localparam logic [15:0] RAMP_MUL   = 16'd191;
	localparam logic [15:0] RAMP_ROUND = 16'd127;
	localparam logic [7:0]  T_HIGH     = 8'd128;
	localparam logic [7:0]  T_MID      = 8'd64;

	typedef struct packed {
		logic [7:0] heat;
		logic       last;
	} heat_beat_t;

endpackage

// ----- rtl/core/fhps_heat.sv -----
module fhps_heat #(
	parameter int PIXELS = fhps_pkg::PIXELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [7:0]            cooldown,
	input  logic [7:0]            spark_roll,
	input  logic [2:0]            spark_pos,
	input  logic [7:0]            spark_add,
	input  logic [6:0]            num_pixels,
	input  logic [7:0]            spark_chance,
	output fhps_pkg::heat_beat_t  beat
);
	import fhps_pkg::*;

	localparam int CW  = $clog2(PIXELS);
	localparam int FW  = $clog2(PIXELS + 1);
	localparam int LW  = ((FW > 7) ? FW : 7) + 1;
	localparam int CMW = (CW > 3) ? CW : 3;

	logic [7:0]    mem [PIXELS];
	logic [7:0]    mem_rd_q;
	logic          rd_valid_q;
	logic          byp_q;
	logic [7:0]    byp_heat_q;

	logic [CW-1:0] cnt_q, cnt_next, rd_addr;
	logic [FW-1:0] fill_q;
	logic [7:0]    prev1_q, prev2_q;
	logic          hit_q;
	logic [2:0]    at_q;
	logic [7:0]    amt_q;

	logic [LW-1:0] frame_len, cnt_plus1;
	logic          last, first;
	logic [7:0]    cur_heat, cooled;
	logic          hit;
	logic [2:0]    at;
	logic [7:0]    amt;
	logic [9:0]    diff_sum;
	logic [19:0]   diff_prod;
	logic [7:0]    base;
	logic          on_spark;
	logic [8:0]    spark_sum;
	logic [7:0]    heat;

	always_comb begin
		if (num_pixels == 7'd0) begin
			frame_len = LW'(1);
		end else if (LW'(num_pixels) > LW'(PIXELS)) begin
			frame_len = LW'(PIXELS);
		end else begin
			frame_len = LW'(num_pixels);
		end
		cnt_plus1 = LW'(cnt_q) + LW'(1);
		last      = (cnt_plus1 >= frame_len);
		cnt_next  = last ? '0 : cnt_q + CW'(1);
		rd_addr   = accept ? cnt_next : cnt_q;
		first     = (cnt_q == '0);

		// entries past the fill count were never written: they read as zero
		cur_heat = byp_q ? byp_heat_q : (rd_valid_q ? mem_rd_q : 8'd0);
		cooled   = (cooldown > cur_heat) ? 8'd0 : cur_heat - cooldown;

		hit = first ? (spark_roll < spark_chance) : hit_q;
		at  = first ? spark_pos : at_q;
		amt = first ? spark_add : amt_q;

		diff_sum  = {2'b00, prev1_q} + {1'b0, prev2_q, 1'b0};
		diff_prod = 20'(diff_sum) * DIV3_MUL;
		base      = (cnt_q >= CW'(2)) ? diff_prod[DIV3_SHIFT +: 8] : cooled;

		on_spark  = hit && (CMW'(cnt_q) == CMW'(at));
		spark_sum = {1'b0, base} + (on_spark ? {1'b0, amt} : 9'd0);
		heat      = spark_sum[8] ? 8'hFF : spark_sum[7:0];

		beat.heat = heat;
		beat.last = last;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mem[cnt_q] <= heat;
		end
		mem_rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			fill_q     <= '0;
			prev1_q    <= '0;
			prev2_q    <= '0;
			hit_q      <= 1'b0;
			at_q       <= '0;
			amt_q      <= '0;
			rd_valid_q <= 1'b0;
			byp_q      <= 1'b1;
			byp_heat_q <= '0;
		end else begin
			// one-pixel frames read back the entry written on this edge
			byp_q      <= accept && (cnt_next == cnt_q);
			byp_heat_q <= heat;
			rd_valid_q <= (FW'(rd_addr) < fill_q);
			if (accept) begin
				cnt_q <= cnt_next;
				if (FW'(cnt_q) == fill_q) begin
					fill_q <= fill_q + FW'(1);
				end
				if (first) begin
					hit_q <= hit;
					at_q  <= at;
					amt_q <= amt;
				end
				if (last) begin
					prev1_q <= '0;
					prev2_q <= '0;
				end else begin
					prev1_q <= cooled;
					prev2_q <= prev1_q;
				end
			end
		end
	end

endmodule

// ----- rtl/core/fhps_color.sv -----
module fhps_color (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  fhps_pkg::heat_beat_t in_beat,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           red,
	output logic [7:0]           green,
	output logic [7:0]           blue,
	output logic                 out_last
);
	import fhps_pkg::*;

	logic        valid_s1, valid_s2, out_valid_q;
	logic [7:0]  heat_s1;
	logic        last_s1, last_s2, last_q;
	logic [15:0] scaled_s2;
	logic [7:0]  red_q, green_q, blue_q;

	logic        out_free, s2_free, s1_free;
	logic [16:0] sp1, t_sum;
	logic [7:0]  t192, ramp;
	logic [7:0]  r_n, g_n, b_n;

	assign out_free = !out_valid_q || out_ready;
	assign s2_free  = !valid_s2 || out_free;
	assign s1_free  = !valid_s1 || s2_free;
	assign in_ready = s1_free;

	always_comb begin
		// x/255 = (x + 1 + ((x + 1) >> 8)) >> 8 over this range
		sp1   = 17'(scaled_s2) + 17'd1;
		t_sum = sp1 + (sp1 >> 8);
		t192  = t_sum[15:8];
		ramp  = {t192[5:0], 2'b00};
		if (t192 > T_HIGH) begin
			r_n = 8'hFF;
			g_n = 8'hFF;
			b_n = ramp;
		end else if (t192 > T_MID) begin
			r_n = 8'hFF;
			g_n = ramp;
			b_n = 8'h00;
		end else begin
			r_n = ramp;
			g_n = 8'h00;
			b_n = 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= in_valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (out_free) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && in_valid) begin
			heat_s1 <= in_beat.heat;
			last_s1 <= in_beat.last;
		end
		if (s2_free && valid_s1) begin
			scaled_s2 <= 16'(heat_s1) * RAMP_MUL + RAMP_ROUND;
			last_s2   <= last_s1;
		end
		if (out_free && valid_s2) begin
			red_q   <= r_n;
			green_q <= g_n;
			blue_q  <= b_n;
			last_q  <= last_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign red       = red_q;
	assign green     = green_q;
	assign blue      = blue_q;
	assign out_last  = last_q;

endmodule

// ----- rtl/core/fire_heat_pixel_stream.sv -----
// channel | dir | handshake         | payload
// s_      | in  | s_tvalid/s_tready | s_tdata: cooldown, spark_roll, spark_pos, spark_add
// m_      | out | m_tvalid/m_tready | m_tdata: red, green, blue; m_tlast: last_pixel
// cfg_    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One pixel per cycle sustained unless m_ stalls. The heat store does a read-modify-write
// per beat: the next pixel's entry is fetched on the accept edge, with a bypass for
// one-pixel frames. Results are registered through two color stages plus an output register.
// Reset empties the heat store at once through a fill count; no clearing pass.
// Stalls on m_ back up the color stages; s_tready drops only when all stages are full.
module fire_heat_pixel_stream #(
	parameter int PIXELS = fhps_pkg::PIXELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [7:0] cooldown, [15:8] spark_roll, [18:16] spark_pos,
	                               // [26:19] spark_add, [31:27] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);
	import fhps_pkg::*;

	logic [6:0] num_pixels_q;
	logic [7:0] spark_chance_q;
	logic       accept;
	heat_beat_t beat;
	logic [7:0] red, green, blue;

	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_pixels_q   <= NUM_PIXELS_RST;
			spark_chance_q <= SPARK_CHANCE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_NUM_PIXELS:   num_pixels_q   <= cfg_data[6:0];
				CFG_SPARK_CHANCE: spark_chance_q <= cfg_data;
				default: ;
			endcase
		end
	end

	fhps_heat #(
		.PIXELS(PIXELS)
	) u_heat (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.cooldown     (s_tdata[7:0]),
		.spark_roll   (s_tdata[15:8]),
		.spark_pos    (s_tdata[18:16]),
		.spark_add    (s_tdata[26:19]),
		.num_pixels   (num_pixels_q),
		.spark_chance (spark_chance_q),
		.beat         (beat)
	);

	fhps_color u_color (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_beat   (beat),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.out_last  (m_tlast)
	);

	assign m_tdata = {blue, green, red};

endmodule
